// ===== design/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg : shared types and constants for the text console writer
// Beat layouts of the command and response channels, command codes and the
// default screen geometry.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 25;

    localparam int CURSOR_W = 15;
    localparam int CELL_W   = 16;

    localparam logic [7:0] CH_NUL     = 8'd0;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_RETURN  = 8'd13;

    typedef enum logic [2:0] {
        CMD_PUT   = 3'd0,
        CMD_LEFT  = 3'd1,
        CMD_RIGHT = 3'd2,
        CMD_CLEAR = 3'd3,
        CMD_READ  = 3'd4
    } tcw_cmd_t;

    typedef struct packed {
        logic [2:0]          cmd;
        logic [7:0]          character;
        logic [7:0]          color;
        logic [CURSOR_W-1:0] step;
        logic [10:0]         cell_address;
    } tcw_in_t;

    typedef struct packed {
        logic [7:0]          read_char;
        logic [7:0]          read_color;
        logic [CURSOR_W-1:0] cursor;
        logic                scrolled;
    } tcw_out_t;

    // status of the column remainder unit
    typedef struct packed {
        logic                done;
        logic [CURSOR_W-1:0] rem;
    } tcw_mod_status_t;

endpackage

// ===== design/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer : text-mode console with scrolling screen store
// Keeps a COLUMNS x ROWS screen of character/colour cells and a cursor.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel carries one command beat (put, left, right, clear, read);
//   rsp channel returns exactly one beat per command with the read-back cell,
//   the cursor after the command and a scroll flag. One command is in flight
//   at a time: cmd_ready is high only while the block is idle.
// Sequence from the accepting edge to the response beat (one write port and
//   one registered read port on the screen store): an ordinary character or
//   NUL passes a check and a put state; a newline or return passes them, then
//   waits on the column remainder unit; a read passes one read state; a move
//   or unused code goes straight to the response; clear writes every cell once.
//   A put that scrolls first reads each cell below the first row and writes it
//   a row up, then blanks the last row. The block returns to idle in the cycle
//   after the response beat is taken.
// Reset: the cursor goes to zero and a clearing pass writes every cell to
//   zero, during which cmd_ready stays low.
// Stall: the response beat is held in registers until rsp_ready; no new
//   command is taken meanwhile.
// ----------------------------------------------------------------------------
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  tcw_pkg::tcw_in_t  cmd_data,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output tcw_pkg::tcw_out_t rsp_data
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int LIMIT = CELLS - COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int CMPW  = CURSOR_W + 1;

    typedef enum logic [10:0] {
        S_INIT   = 11'b00000000001,
        S_IDLE   = 11'b00000000010,
        S_CHECK  = 11'b00000000100,
        S_SCR_RD = 11'b00000001000,
        S_SCR_WR = 11'b00000010000,
        S_BLANK  = 11'b00000100000,
        S_PUT    = 11'b00001000000,
        S_MOD    = 11'b00010000000,
        S_CLEAR  = 11'b00100000000,
        S_READ   = 11'b01000000000,
        S_DONE   = 11'b10000000000
    } tcw_state_t;

    tcw_state_t          state_reg,  state_next;
    tcw_in_t             item_reg,   item_next;
    logic [CURSOR_W-1:0] cursor_reg, cursor_next;
    logic [AW-1:0]       idx_reg,    idx_next;
    logic                scrolled_reg, scrolled_next;
    logic                rd_hit_reg,   rd_hit_next;

    logic [CELL_W-1:0]   mem [CELLS];
    logic [CELL_W-1:0]   rdata_reg;
    logic                wr_en, rd_en;
    logic [AW-1:0]       wr_addr, rd_addr;
    logic [CELL_W-1:0]   wr_data;

    logic                mod_start;
    logic [CURSOR_W-1:0] mod_value;
    tcw_mod_status_t     mod_status;

    logic                accept;
    logic                idx_last;

    assign accept   = cmd_valid && cmd_ready;
    assign idx_last = (idx_reg == AW'(CELLS - 1));

    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        cursor_next   = cursor_reg;
        idx_next      = idx_reg;
        scrolled_next = scrolled_reg;
        rd_hit_next   = rd_hit_reg;
        wr_en         = 1'b0;
        wr_addr       = idx_reg;
        wr_data       = '0;
        rd_en         = 1'b0;
        rd_addr       = idx_reg;
        mod_start     = 1'b0;
        mod_value     = cursor_reg;

        unique case (state_reg)
            S_INIT, S_CLEAR:
            begin
                wr_en = 1'b1;
                if (idx_last)
                begin
                    cursor_next = '0;
                    state_next  = (state_reg == S_INIT) ? S_IDLE : S_DONE;
                end
                else
                    idx_next = idx_reg + AW'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    item_next     = cmd_data;
                    scrolled_next = 1'b0;
                    rd_hit_next   = 1'b0;
                    idx_next      = '0;
                    unique case (cmd_data.cmd)
                        CMD_PUT:   state_next = S_CHECK;
                        CMD_LEFT:
                        begin
                            cursor_next = cursor_reg - cmd_data.step;
                            state_next  = S_DONE;
                        end
                        CMD_RIGHT:
                        begin
                            cursor_next = cursor_reg + cmd_data.step;
                            state_next  = S_DONE;
                        end
                        CMD_CLEAR: state_next = S_CLEAR;
                        CMD_READ:  state_next = S_READ;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_CHECK:
            begin
                if (CMPW'(cursor_reg) >= CMPW'(CELLS))
                begin
                    scrolled_next = 1'b1;
                    state_next    = S_SCR_RD;
                end
                else
                    state_next = S_PUT;
            end
            S_SCR_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg + AW'(COLUMNS);
                state_next = S_SCR_WR;
            end
            S_SCR_WR:
            begin
                wr_en   = 1'b1;
                wr_data = rdata_reg;
                idx_next = idx_reg + AW'(1);
                state_next = (idx_reg == AW'(LIMIT - 1)) ? S_BLANK : S_SCR_RD;
            end
            S_BLANK:
            begin
                wr_en = 1'b1;
                if (idx_last)
                begin
                    cursor_next = CURSOR_W'(LIMIT);
                    state_next  = S_PUT;
                end
                else
                    idx_next = idx_reg + AW'(1);
            end
            S_PUT:
            begin
                priority if (item_reg.character == CH_NEWLINE)
                begin
                    cursor_next = cursor_reg + CURSOR_W'(COLUMNS);
                    mod_value   = cursor_next;
                    mod_start   = 1'b1;
                    state_next  = S_MOD;
                end
                else if (item_reg.character == CH_RETURN)
                begin
                    mod_start  = 1'b1;
                    state_next = S_MOD;
                end
                else if (item_reg.character == CH_NUL)
                    state_next = S_DONE;
                else
                begin
                    // cursor is on screen here, any scroll has already run
                    wr_en       = (CMPW'(cursor_reg) < CMPW'(CELLS));
                    wr_addr     = AW'(cursor_reg);
                    wr_data     = {item_reg.color, item_reg.character};
                    cursor_next = cursor_reg + CURSOR_W'(1);
                    state_next  = S_DONE;
                end
            end
            S_MOD:
            begin
                if (mod_status.done)
                begin
                    cursor_next = cursor_reg - mod_status.rem;
                    state_next  = S_DONE;
                end
            end
            S_READ:
            begin
                if (CMPW'(item_reg.cell_address) < CMPW'(CELLS))
                begin
                    rd_en       = 1'b1;
                    rd_addr     = AW'(item_reg.cell_address);
                    rd_hit_next = 1'b1;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            cursor_reg   <= '0;
            idx_reg      <= '0;
            scrolled_reg <= 1'b0;
            rd_hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cursor_reg   <= cursor_next;
            idx_reg      <= idx_next;
            scrolled_reg <= scrolled_next;
            rd_hit_reg   <= rd_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    // screen store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    tcw_mod_unit #(
        .COLUMNS (COLUMNS)
    ) u_mod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mod_start),
        .value  (mod_value),
        .status (mod_status)
    );

    assign cmd_ready           = (state_reg == S_IDLE);
    assign rsp_valid           = (state_reg == S_DONE);
    assign rsp_data.read_char  = rd_hit_reg ? rdata_reg[7:0]  : 8'd0;
    assign rsp_data.read_color = rd_hit_reg ? rdata_reg[15:8] : 8'd0;
    assign rsp_data.cursor     = cursor_reg;
    assign rsp_data.scrolled   = scrolled_reg;

    a_one_side_open: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd_ready && rsp_valid))
        else $error("command and response sides open together");

    a_scroll_only_on_put: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.scrolled |-> item_reg.cmd == CMD_PUT)
        else $error("scroll flagged on a non-put command");

    a_read_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && item_reg.cmd != CMD_READ |->
            rsp_data.read_char == 8'd0 && rsp_data.read_color == 8'd0)
        else $error("read fields set on a non-read command");

    a_write_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (32'(wr_addr) < CELLS))
        else $error("screen write beyond last cell");

    a_scroll_lands_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_BLANK && idx_last |=> cursor_reg == CURSOR_W'(LIMIT))
        else $error("scroll left cursor off the last row");

endmodule

// ===== design/tcw_mod_unit.sv =====
// ----------------------------------------------------------------------------
// tcw_mod_unit : cursor-modulo-columns unit
// Reciprocal multiply for the row number is registered, then the unit
// multiplies back and subtracts; remainder and done are registered together.
// ----------------------------------------------------------------------------
module tcw_mod_unit #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tcw_pkg::CURSOR_W-1:0]  value,
    output tcw_pkg::tcw_mod_status_t      status
);
    import tcw_pkg::*;

    // ceil(2^SH / COLUMNS) gives an exact quotient for every CURSOR_W-bit value
    localparam int LW = $clog2(COLUMNS);
    localparam int SH = CURSOR_W + LW;
    localparam int MW = CURSOR_W + 1;
    localparam int PW = CURSOR_W + MW;
    localparam int QW = PW - SH;
    localparam logic [MW-1:0] MULT = MW'(((1 << SH) + COLUMNS - 1) / COLUMNS);

    logic [PW-1:0]       prod_reg, prod_next;
    logic [CURSOR_W-1:0] val_reg,  val_next;
    logic [CURSOR_W-1:0] rem_reg,  rem_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    logic [QW-1:0]       quot;
    logic [CURSOR_W-1:0] back;

    assign quot = prod_reg[PW-1:SH];
    assign back = CURSOR_W'(quot) * CURSOR_W'(COLUMNS);

    always_comb
    begin
        prod_next = prod_reg;
        val_next  = val_reg;
        rem_next  = rem_reg;
        busy_next = 1'b0;
        done_next = 1'b0;
        if (start)
        begin
            prod_next = PW'(value) * PW'(MULT);
            val_next  = value;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // take away whole rows
            rem_next  = val_reg - back;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        val_reg  <= val_next;
        rem_reg  <= rem_next;
    end

    assign status.done = done_reg;
    assign status.rem  = rem_reg;

    a_rem_below_columns: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (32'(rem_reg) < COLUMNS))
        else $error("remainder not below column count");

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("remainder unit restarted while busy");

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("done without a finished run");

endmodule
